/* design/fbc16_pkg.sv */
// ---------------------------------------------------------------------------
// fbc16_pkg
// Shared types, register codes, S-box tables and round function for the
// 16-bit Feistel block cipher.
// ---------------------------------------------------------------------------
package fbc16_pkg;

    localparam int HALF_W = 8;
    localparam int CNT_W  = 8;
    localparam int ROT_W  = 3;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (byte address = 4 * index)
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_ROUND_COUNT   = 2'd0;
    localparam reg_idx_t REG_ROTATE_AMOUNT = 2'd1;
    localparam reg_idx_t REG_ROUND_KEY     = 2'd2;

    // Reset values
    localparam logic [CNT_W-1:0]  RST_ROUND_COUNT   = 8'd32;
    localparam logic [ROT_W-1:0]  RST_ROTATE_AMOUNT = 3'd3;
    localparam logic [HALF_W-1:0] RST_ROUND_KEY     = 8'd0;

    typedef struct packed {
        logic [HALF_W-1:0] left_half;
        logic [HALF_W-1:0] right_half;
    } in_item_t;

    typedef struct packed {
        logic [HALF_W-1:0] out_left;
        logic [HALF_W-1:0] out_right;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]  round_count;
        logic [ROT_W-1:0]  rotate_amount;
        logic [HALF_W-1:0] round_key;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // take a new request into the working halves
        logic load_zero;  // zero-round request: working halves cleared
        logic do_round;   // apply one round
        logic emit;       // copy working halves to the output register
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
    } dp_status_t;

    function automatic logic [3:0] sbox_high(input logic [3:0] v);
        logic [3:0] r;
        case (v)
            4'h0:    r = 4'd4;
            4'h1:    r = 4'd11;
            4'h2:    r = 4'd2;
            4'h3:    r = 4'd14;
            4'h4:    r = 4'd15;
            4'h5:    r = 4'd0;
            4'h6:    r = 4'd8;
            4'h7:    r = 4'd13;
            4'h8:    r = 4'd3;
            4'h9:    r = 4'd12;
            4'hA:    r = 4'd9;
            4'hB:    r = 4'd7;
            4'hC:    r = 4'd5;
            4'hD:    r = 4'd10;
            4'hE:    r = 4'd6;
            4'hF:    r = 4'd1;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] sbox_low(input logic [3:0] v);
        logic [3:0] r;
        case (v)
            4'h0:    r = 4'd13;
            4'h1:    r = 4'd2;
            4'h2:    r = 4'd8;
            4'h3:    r = 4'd4;
            4'h4:    r = 4'd6;
            4'h5:    r = 4'd15;
            4'h6:    r = 4'd11;
            4'h7:    r = 4'd1;
            4'h8:    r = 4'd10;
            4'h9:    r = 4'd9;
            4'hA:    r = 4'd3;
            4'hB:    r = 4'd14;
            4'hC:    r = 4'd5;
            4'hD:    r = 4'd0;
            4'hE:    r = 4'd12;
            4'hF:    r = 4'd7;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] rotl8(input logic [HALF_W-1:0] v,
                                                input logic [ROT_W-1:0]  amt);
        logic [2*HALF_W-1:0] d;
        d = {v, v} << amt;
        return d[2*HALF_W-1:HALF_W];
    endfunction

    // Round function: key add, nibble substitution, rotate
    function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] r,
                                                  input logic [HALF_W-1:0] key,
                                                  input logic [ROT_W-1:0]  amt);
        logic [HALF_W-1:0] t;
        logic [HALF_W-1:0] s;
        t = r + key;
        s = {sbox_high(t[7:4]), sbox_low(t[3:0])};
        return rotl8(s, amt);
    endfunction

endpackage

/* design/fbc16_regs.sv */
// ---------------------------------------------------------------------------
// fbc16_regs
// APB-style configuration registers: round count, rotate amount, round key.
// ---------------------------------------------------------------------------
module fbc16_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fbc16_pkg::ADDR_W-1:0]   paddr,
    input  logic [fbc16_pkg::DATA_W-1:0]   pwdata,
    output logic [fbc16_pkg::DATA_W-1:0]   prdata,
    output logic                           pready,
    output fbc16_pkg::cfg_t                cfg
);

    fbc16_pkg::cfg_t   cfg_reg;
    fbc16_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.round_count   <= fbc16_pkg::RST_ROUND_COUNT;
            cfg_reg.rotate_amount <= fbc16_pkg::RST_ROTATE_AMOUNT;
            cfg_reg.round_key     <= fbc16_pkg::RST_ROUND_KEY;
        end
        else if (wr_en)
        begin
            case (idx)
                fbc16_pkg::REG_ROUND_COUNT:
                    cfg_reg.round_count <= pwdata[fbc16_pkg::CNT_W-1:0];
                fbc16_pkg::REG_ROTATE_AMOUNT:
                    cfg_reg.rotate_amount <= pwdata[fbc16_pkg::ROT_W-1:0];
                fbc16_pkg::REG_ROUND_KEY:
                    cfg_reg.round_key <= pwdata[fbc16_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            fbc16_pkg::REG_ROUND_COUNT:
                prdata = {{(fbc16_pkg::DATA_W-fbc16_pkg::CNT_W){1'b0}},
                          cfg_reg.round_count};
            fbc16_pkg::REG_ROTATE_AMOUNT:
                prdata = {{(fbc16_pkg::DATA_W-fbc16_pkg::ROT_W){1'b0}},
                          cfg_reg.rotate_amount};
            fbc16_pkg::REG_ROUND_KEY:
                prdata = {{(fbc16_pkg::DATA_W-fbc16_pkg::HALF_W){1'b0}},
                          cfg_reg.round_key};
            default:
                prdata = '0;
        endcase
    end

endmodule

/* design/fbc16_ctrl.sv */
// ---------------------------------------------------------------------------
// fbc16_ctrl
// Sequencer: accepts a request, counts the rounds, hands the result over.
// ---------------------------------------------------------------------------
module fbc16_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fbc16_pkg::CNT_W-1:0]   round_count,
    input  fbc16_pkg::dp_status_t         status,
    output fbc16_pkg::dp_cmd_t            cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT
    } state_t;

    state_t                        state_reg, state_next;
    logic [fbc16_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                          take_out;
    logic                          can_accept;
    logic                          accept;

    // Handover and acceptance
    assign take_out   = (state_reg == ST_WAIT) && status.out_free;
    assign can_accept = (state_reg == ST_IDLE) || take_out;
    assign in_stall   = !can_accept;
    assign accept     = in_valid && can_accept;

    assign cmd.load      = accept;
    assign cmd.load_zero = accept && (round_count == '0);
    assign cmd.do_round  = (state_reg == ST_RUN);
    assign cmd.emit      = take_out;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: ;
            ST_RUN:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == {{(fbc16_pkg::CNT_W-1){1'b0}}, 1'b1})
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (take_out)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
        // New request (also taken in the cycle the old result leaves)
        if (accept)
        begin
            cnt_next   = round_count;
            state_next = (round_count == '0) ? ST_WAIT : ST_RUN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* design/fbc16_dp.sv */
// ---------------------------------------------------------------------------
// fbc16_dp
// Datapath: working halves, one round per cycle, output register.
// ---------------------------------------------------------------------------
module fbc16_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fbc16_pkg::dp_cmd_t             cmd,
    input  fbc16_pkg::in_item_t            in_data,
    input  fbc16_pkg::cfg_t                cfg,
    output fbc16_pkg::out_item_t           out_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output fbc16_pkg::dp_status_t          status
);

    logic [fbc16_pkg::HALF_W-1:0] left_reg, left_next;
    logic [fbc16_pkg::HALF_W-1:0] right_reg, right_next;
    logic [fbc16_pkg::HALF_W-1:0] f_val;
    fbc16_pkg::out_item_t         out_data_reg;
    logic                         out_valid_reg, out_valid_next;

    assign f_val = fbc16_pkg::round_f(right_reg, cfg.round_key, cfg.rotate_amount);

    // Working halves
    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        if (cmd.load_zero)
        begin
            left_next  = '0;
            right_next = '0;
        end
        else if (cmd.load)
        begin
            left_next  = in_data.left_half;
            right_next = in_data.right_half;
        end
        else if (cmd.do_round)
        begin
            left_next  = right_reg;
            right_next = f_val ^ left_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    // Output register
    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid_next  = cmd.emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.out_left  <= left_reg;
            out_data_reg.out_right <= right_reg;
        end
    end

    assign out_data  = out_data_reg;
    assign out_valid = out_valid_reg;

endmodule

/* design/feistel_block_cipher_16bit.sv */
// Rounds are applied one round per cycle in a shared unit. The next request
// is taken in the cycle the previous result moves to the output register,
// which needs that register empty or being read that cycle, so a new request
// is not taken while the previous one is still at work.
// Reset: rst_n clears control and loads the register reset values.
// ---------------------------------------------------------------------------
// feistel_block_cipher_16bit
// 16-bit GOST-style Feistel cipher with configurable rounds, rotation and key.
// ---------------------------------------------------------------------------
module feistel_block_cipher_16bit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  fbc16_pkg::in_item_t            in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output fbc16_pkg::out_item_t           out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fbc16_pkg::ADDR_W-1:0]   paddr,
    input  logic [fbc16_pkg::DATA_W-1:0]   pwdata,
    output logic [fbc16_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);

    fbc16_pkg::cfg_t        cfg;
    fbc16_pkg::dp_cmd_t     cmd;
    fbc16_pkg::dp_status_t  status;

    fbc16_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbc16_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .round_count (cfg.round_count),
        .status      (status),
        .cmd         (cmd)
    );

    fbc16_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg       (cfg),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status)
    );

endmodule

/* design/fbc16_chk.sv */
// ---------------------------------------------------------------------------
// fbc16_chk
// Port-level checks for the Feistel cipher, bound to the top level.
// ---------------------------------------------------------------------------
module fbc16_chk (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  fbc16_pkg::out_item_t           out_data,
    input  logic                           pready
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Requests taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
    end

    // Leaving reset: no result showing and the input open
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> (!out_valid && !in_stall))
        else $error("block not idle after reset");

    // No result without an outstanding request
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pend_reg != 2'd0))
        else $error("result shown with no request outstanding");

    // At most one request at work plus one result waiting
    a_max_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many requests outstanding");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    // Register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind feistel_block_cipher_16bit fbc16_chk u_fbc16_chk (.*);
